// ===== src/ambr_pkg.sv =====
// ----------------------------------------------------------------------------
// ambr_pkg
// shared types and constants of the axis move resolver
// ----------------------------------------------------------------------------
package ambr_pkg;

  // fixed field widths of the item channels
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned SIZE_W   = 15;

  // defaults for the top level parameters
  localparam int unsigned AMBR_MAX_COLLIDERS = 64;
  localparam int unsigned AMBR_COORD_BITS    = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SETPOS = 2'd1,
    ACT_MOVE   = 2'd2
  } ambr_action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SELF,
    ST_PREP,
    ST_PREP2,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ambr_state_e;

  // status of the shared overlap unit
  typedef struct packed {
    logic hit_x;
    logic hit_y;
    logic busy;
  } ambr_scan_sts_t;

endpackage

// ===== src/ambr_in_if.sv =====
// ----------------------------------------------------------------------------
// ambr_in_if
// input item channel: valid, ready and the request payload
// ----------------------------------------------------------------------------
interface ambr_in_if
  import ambr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [SLOT_W-1:0]         slot;
  logic signed [FIELD_W-1:0] rect_x;
  logic signed [FIELD_W-1:0] rect_y;
  logic [SIZE_W-1:0]         rect_w;
  logic [SIZE_W-1:0]         rect_h;
  logic signed [FIELD_W-1:0] offset_x;
  logic signed [FIELD_W-1:0] offset_y;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] move_x;
  logic signed [FIELD_W-1:0] move_y;

  modport source (
    output valid, action, slot, rect_x, rect_y, rect_w, rect_h,
    output offset_x, offset_y, pos_x, pos_y, move_x, move_y,
    input  ready
  );

  modport sink (
    input  valid, action, slot, rect_x, rect_y, rect_w, rect_h,
    input  offset_x, offset_y, pos_x, pos_y, move_x, move_y,
    output ready
  );
endinterface

// ===== src/ambr_out_if.sv =====
// ----------------------------------------------------------------------------
// ambr_out_if
// result item channel: valid, ready and the granted move
// ----------------------------------------------------------------------------
interface ambr_out_if
  import ambr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vel_x;
  logic signed [FIELD_W-1:0] vel_y;
  logic                      had_collider;

  modport source (
    output valid, vel_x, vel_y, had_collider,
    input  ready
  );

  modport sink (
    input  valid, vel_x, vel_y, had_collider,
    output ready
  );
endinterface

// ===== src/aabb_axis_move_resolver.sv =====
// ----------------------------------------------------------------------------
// aabb_axis_move_resolver
// axis-separated move resolver over a table of collider rectangles
// ----------------------------------------------------------------------------
// usage
//   in_i carries load, set-position and move items; out_o returns one
//   result item per move item unless both axes are blocked
//   load: writes the slot and marks it valid, unless it is beyond the table
//   set position: reads the slot, then writes the new origin if the slot
//   holds a collider; a slot beyond the table is ignored
//   move: the sequencer reads the own slot, builds both trial rectangles
//   in the PREP and PREP2 states, then streams the table through the
//   single memory read port into the shared overlap unit, one entry a
//   cycle, and waits in DRAIN for the last entry to leave the unit; when
//   both axes are blocked it returns to idle without a result
//   a move on a slot without collider, or beyond the table, skips the scan
//   in_i.ready is high only while the sequencer waits for an item
//   out_o holds its result in a register, so the next item is taken while
//   a result waits; a finished move waits only if that register is full
//   reset: a clearing pass writes every table entry invalid, in_i.ready
//   stays low during it
// ----------------------------------------------------------------------------
module aabb_axis_move_resolver
  import ambr_pkg::*;
#(
  parameter int unsigned MAX_COLLIDERS = AMBR_MAX_COLLIDERS,
  parameter int unsigned COORD_BITS    = AMBR_COORD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ambr_in_if.sink    in_i,
  ambr_out_if.source out_o
);

  localparam int unsigned IW    = $clog2(MAX_COLLIDERS);
  localparam int unsigned CB    = COORD_BITS;
  // full precision for origin + move + size
  localparam int unsigned SUM_W = ((CB > FIELD_W) ? CB : FIELD_W) + 3;
  // table word: {valid, x, y, w, h, off_x, off_y}
  localparam int unsigned EW    = 4 * CB + 2 * SIZE_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_COLLIDERS - 1);
  localparam logic signed [33:0] CMAX = (34'sd1 <<< (CB - 1)) - 34'sd1;
  localparam logic signed [33:0] CMIN = -CMAX - 34'sd1;

  // clamp to the signed coordinate range
  function automatic logic signed [CB-1:0] sat_coord(input logic signed [33:0] v);
    if (v > CMAX) begin
      return CB'(CMAX);
    end else if (v < CMIN) begin
      return CB'(CMIN);
    end
    return CB'(v);
  endfunction

  ambr_state_e state_q, state_d;

  // latched item
  ambr_action_e            act_q;
  logic [IW-1:0]           slot_q;
  logic signed [FIELD_W-1:0] pos_x_q, pos_y_q, mx_q, my_q;

  // own rectangle and trial edges
  logic signed [CB-1:0]    self_x_q, self_y_q;
  logic [SIZE_W-1:0]       self_w_q, self_h_q;
  logic                    self_ne_q, has_q;
  logic signed [SUM_W-1:0] tx0_q, tx1_q, ty0_q, ty1_q;
  logic signed [SUM_W-1:0] ox0_q, ox1_q, oy0_q, oy1_q;

  // scan and clear counters
  logic [IW-1:0] scan_idx_q, clr_idx_q;
  logic          tag_vld_q;
  logic [IW-1:0] tag_idx_q;

  // output register
  logic                      out_vld_q;
  logic signed [FIELD_W-1:0] vel_x_q, vel_y_q;
  logic                      had_q;

  // table port
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr, tbl_raddr;
  logic [EW-1:0] tbl_wdata, tbl_rdata;

  // sequencer strobes
  logic accept, in_tab, rd_issue, self_load, out_load;
  logic [IW-1:0] in_idx;
  ambr_action_e  in_act;
  ambr_scan_sts_t sts;

  // table word fields
  logic                 rd_vld;
  logic signed [CB-1:0] rd_x, rd_y, rd_ox, rd_oy;
  logic [SIZE_W-1:0]    rd_w, rd_h;
  logic [EW-1:0]        load_word, setpos_word;
  logic                 consider;

  assign rd_oy  = tbl_rdata[CB-1:0];
  assign rd_ox  = tbl_rdata[2*CB-1:CB];
  assign rd_h   = tbl_rdata[2*CB+SIZE_W-1:2*CB];
  assign rd_w   = tbl_rdata[2*CB+2*SIZE_W-1:2*CB+SIZE_W];
  assign rd_y   = tbl_rdata[3*CB+2*SIZE_W-1:2*CB+2*SIZE_W];
  assign rd_x   = tbl_rdata[4*CB+2*SIZE_W-1:3*CB+2*SIZE_W];
  assign rd_vld = tbl_rdata[EW-1];

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_act     = ambr_action_e'(in_i.action);
  assign in_tab     = (32'(in_i.slot) < 32'(MAX_COLLIDERS));
  assign in_idx     = IW'(in_i.slot);

  assign load_word = {1'b1,
                      sat_coord(34'(in_i.rect_x)), sat_coord(34'(in_i.rect_y)),
                      in_i.rect_w, in_i.rect_h,
                      sat_coord(34'(in_i.offset_x)), sat_coord(34'(in_i.offset_y))};

  // new origin is position plus stored offset
  assign setpos_word = {1'b1,
                        sat_coord(34'(pos_x_q) + 34'(rd_ox)),
                        sat_coord(34'(pos_y_q) + 34'(rd_oy)),
                        rd_w, rd_h, rd_ox, rd_oy};

  // next state and strobes
  always_comb begin
    state_d   = state_q;
    tbl_we    = 1'b0;
    tbl_waddr = clr_idx_q;
    tbl_wdata = '0;
    tbl_raddr = scan_idx_q;
    rd_issue  = 1'b0;
    self_load = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        if (clr_idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_LOAD: begin
              tbl_we    = in_tab;
              tbl_waddr = in_idx;
              tbl_wdata = load_word;
            end
            ACT_SETPOS: begin
              tbl_raddr = in_idx;
              if (in_tab) begin
                state_d = ST_SELF;
              end
            end
            ACT_MOVE: begin
              tbl_raddr = in_idx;
              state_d   = in_tab ? ST_SELF : ST_DONE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SELF: begin
        // own entry is on the read port now
        if (act_q == ACT_SETPOS) begin
          tbl_we    = rd_vld;
          tbl_waddr = slot_q;
          tbl_wdata = setpos_word;
          state_d   = ST_IDLE;
        end else if (rd_vld) begin
          self_load = 1'b1;
          state_d   = ST_PREP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PREP: begin
        state_d = ST_PREP2;
      end
      ST_PREP2: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_issue = 1'b1;
        if (scan_idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until the last entry has left the overlap unit
        if (!tag_vld_q && !sts.busy) begin
          state_d = (sts.hit_x && sts.hit_y) ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_idx_q  <= '0;
      scan_idx_q <= '0;
      tag_vld_q  <= 1'b0;
      has_q      <= 1'b0;
      self_ne_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      tag_vld_q <= rd_issue;
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + IW'(1);
      end
      if (accept) begin
        scan_idx_q <= '0;
        has_q      <= 1'b0;
      end else if (rd_issue) begin
        scan_idx_q <= scan_idx_q + IW'(1);
      end
      if (self_load) begin
        has_q     <= 1'b1;
        self_ne_q <= (rd_w != '0) && (rd_h != '0);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tag_idx_q <= scan_idx_q;
    if (accept) begin
      act_q   <= in_act;
      slot_q  <= in_idx;
      pos_x_q <= in_i.pos_x;
      pos_y_q <= in_i.pos_y;
      mx_q    <= in_i.move_x;
      my_q    <= in_i.move_y;
    end
    if (self_load) begin
      self_x_q <= rd_x;
      self_y_q <= rd_y;
      self_w_q <= rd_w;
      self_h_q <= rd_h;
    end
    if (state_q == ST_PREP) begin
      ox0_q <= SUM_W'(self_x_q);
      oy0_q <= SUM_W'(self_y_q);
      ox1_q <= SUM_W'(self_x_q) + $signed(SUM_W'(self_w_q));
      oy1_q <= SUM_W'(self_y_q) + $signed(SUM_W'(self_h_q));
      tx0_q <= SUM_W'(self_x_q) + SUM_W'(mx_q);
      ty0_q <= SUM_W'(self_y_q) + SUM_W'(my_q);
    end
    if (state_q == ST_PREP2) begin
      tx1_q <= tx0_q + $signed(SUM_W'(self_w_q));
      ty1_q <= ty0_q + $signed(SUM_W'(self_h_q));
    end
    if (out_load) begin
      vel_x_q <= sts.hit_x ? '0 : mx_q;
      vel_y_q <= sts.hit_y ? '0 : my_q;
      had_q   <= has_q;
    end
  end

  // other valid entries only, and only for a non-empty mover
  assign consider = tag_vld_q && rd_vld && (tag_idx_q != slot_q) && self_ne_q;

  ambr_table #(
    .DEPTH (MAX_COLLIDERS),
    .WIDTH (EW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  ambr_overlap_unit #(
    .COORD_BITS (COORD_BITS),
    .SUM_W      (SUM_W)
  ) u_overlap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (accept),
    .ent_vld_i (consider),
    .ent_x_i   (rd_x),
    .ent_y_i   (rd_y),
    .ent_w_i   (rd_w),
    .ent_h_i   (rd_h),
    .tx0_i     (tx0_q),
    .tx1_i     (tx1_q),
    .ty0_i     (ty0_q),
    .ty1_i     (ty1_q),
    .ox0_i     (ox0_q),
    .ox1_i     (ox1_q),
    .oy0_i     (oy0_q),
    .oy1_i     (oy1_q),
    .sts_o     (sts)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.vel_x        = vel_x_q;
  assign out_o.vel_y        = vel_y_q;
  assign out_o.had_collider = had_q;

  // table stays untouched while it is being scanned
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_DRAIN) |-> !tbl_we)
    else $error("table written during scan");

  // scan walks the table one entry a cycle
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && $past(state_q == ST_SCAN)) |->
      (scan_idx_q == $past(scan_idx_q) + IW'(1)))
    else $error("scan index skipped");

  // read tags only live while a scan is in flight
  a_tag_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_vld_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("stray scan read");

  // a result with a collider never has both axes blocked
  a_no_double_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(has_q && sts.hit_x && sts.hit_y))
    else $error("result issued for fully blocked move");

endmodule

// ===== src/ambr_table.sv =====
// ----------------------------------------------------------------------------
// ambr_table
// collider table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ambr_table
  import ambr_pkg::*;
#(
  parameter int unsigned DEPTH = AMBR_MAX_COLLIDERS,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/ambr_overlap_unit.sv =====
// ----------------------------------------------------------------------------
// ambr_overlap_unit
// shared overlap tester, one table entry per cycle against both trials
// ----------------------------------------------------------------------------
module ambr_overlap_unit
  import ambr_pkg::*;
#(
  parameter int unsigned COORD_BITS = AMBR_COORD_BITS,
  parameter int unsigned SUM_W      = 19
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         ent_vld_i,
  input  logic signed [COORD_BITS-1:0] ent_x_i,
  input  logic signed [COORD_BITS-1:0] ent_y_i,
  input  logic [SIZE_W-1:0]            ent_w_i,
  input  logic [SIZE_W-1:0]            ent_h_i,
  // x trial edges
  input  logic signed [SUM_W-1:0]      tx0_i,
  input  logic signed [SUM_W-1:0]      tx1_i,
  // y trial edges
  input  logic signed [SUM_W-1:0]      ty0_i,
  input  logic signed [SUM_W-1:0]      ty1_i,
  // unshifted edges
  input  logic signed [SUM_W-1:0]      ox0_i,
  input  logic signed [SUM_W-1:0]      ox1_i,
  input  logic signed [SUM_W-1:0]      oy0_i,
  input  logic signed [SUM_W-1:0]      oy1_i,
  output ambr_scan_sts_t               sts_o
);

  // stage 1: entry edges
  logic                    s1_vld_q;
  logic signed [SUM_W-1:0] ex0_q, ex1_q, ey0_q, ey1_q;
  logic signed [SUM_W-1:0] ex0_d, ey0_d;
  logic                    hit_x_q, hit_y_q;
  logic                    ov_x, ov_y;

  assign ex0_d = SUM_W'(ent_x_i);
  assign ey0_d = SUM_W'(ent_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ent_vld_i && (ent_w_i != '0) && (ent_h_i != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    ex0_q <= ex0_d;
    ey0_q <= ey0_d;
    ex1_q <= ex0_d + $signed(SUM_W'(ent_w_i));
    ey1_q <= ey0_d + $signed(SUM_W'(ent_h_i));
  end

  // stage 2: strict overlap of both trials
  assign ov_x = (tx0_i < ex1_q) && (ex0_q < tx1_i) && (oy0_i < ey1_q) && (ey0_q < oy1_i);
  assign ov_y = (ox0_i < ex1_q) && (ex0_q < ox1_i) && (ty0_i < ey1_q) && (ey0_q < ty1_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_x_q <= 1'b0;
      hit_y_q <= 1'b0;
    end else if (clear_i) begin
      hit_x_q <= 1'b0;
      hit_y_q <= 1'b0;
    end else if (s1_vld_q) begin
      hit_x_q <= hit_x_q | ov_x;
      hit_y_q <= hit_y_q | ov_y;
    end
  end

  assign sts_o.hit_x = hit_x_q;
  assign sts_o.hit_y = hit_y_q;
  assign sts_o.busy  = s1_vld_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the axis move resolver: a clocked driver feeds load,
// set-position and move items from a queue, a shadow collider table predicts
// every granted move, and a clocked monitor checks each result item in order
// ----------------------------------------------------------------------------
module tb;
  import ambr_pkg::*;

  // table size and coordinate range of the default build
  localparam int NSLOT   = AMBR_MAX_COLLIDERS;
  localparam int CRD_MAX = (1 << (AMBR_COORD_BITS - 1)) - 1;
  localparam int CRD_MIN = -CRD_MAX - 1;

  // the one action code the block has no use for
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // run shape
  localparam int N_RANDOM       = 774;
  localparam int QUIET_TAIL     = 120;
  localparam int DRAIN_CYC      = NSLOT + 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] rect_x;
    logic signed [FIELD_W-1:0] rect_y;
    logic [SIZE_W-1:0]         rect_w;
    logic [SIZE_W-1:0]         rect_h;
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] move_x;
    logic signed [FIELD_W-1:0] move_y;
  } req_t;

  typedef struct {
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic                      had_collider;
  } grant_t;

  logic clk_i;
  logic rst_ni;

  ambr_in_if  in_if ();
  ambr_out_if out_if ();

  aabb_axis_move_resolver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the collider table
  logic signed [FIELD_W-1:0] tbl_x  [NSLOT];
  logic signed [FIELD_W-1:0] tbl_y  [NSLOT];
  logic [SIZE_W-1:0]         tbl_w  [NSLOT];
  logic [SIZE_W-1:0]         tbl_h  [NSLOT];
  logic signed [FIELD_W-1:0] tbl_ox [NSLOT];
  logic signed [FIELD_W-1:0] tbl_oy [NSLOT];
  bit                        tbl_vld[NSLOT];

  req_t   pend_q[$];   // items still to be sent
  grant_t grant_q[$];  // granted moves still to come back
  grant_t due;

  int n_bad    = 0;
  int src_gap  = 0;
  int src_odds = 0;
  int snk_gap  = 0;
  int snk_odds = 0;
  int snk_cyc  = 0;
  int idle_cyc = 0;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    n_bad++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic logic signed [FIELD_W-1:0] clamp_coord(int v);
    if (v > CRD_MAX) return FIELD_W'(CRD_MAX);
    if (v < CRD_MIN) return FIELD_W'(CRD_MIN);
    return FIELD_W'(v);
  endfunction

  // strict overlap of a trial rectangle with table entry k; empty never hits
  function automatic bit boxes_overlap(int ax, int ay, int aw, int ah, int k);
    int bx, by, bw, bh;
    bx = int'(tbl_x[k]);
    by = int'(tbl_y[k]);
    bw = int'(tbl_w[k]);
    bh = int'(tbl_h[k]);
    if (aw <= 0 || ah <= 0 || bw <= 0 || bh <= 0) return 1'b0;
    return (ax < bx + bw) && (bx < ax + aw) && (ay < by + bh) && (by < ay + ah);
  endfunction

  // updates the shadow table for one accepted item and queues the grant of a move not blocked on both axes
  function automatic void resolve_item(req_t r);
    int     s, mx, my, ox, oy, ow, oh, k;
    bit     in_tbl, has, hit_x, hit_y;
    grant_t g;
    s      = int'(r.slot);
    in_tbl = s < NSLOT;
    case (r.action)
      ACT_LOAD: begin
        if (in_tbl) begin
          tbl_x[s]   = clamp_coord(int'(r.rect_x));
          tbl_y[s]   = clamp_coord(int'(r.rect_y));
          tbl_w[s]   = r.rect_w;
          tbl_h[s]   = r.rect_h;
          tbl_ox[s]  = clamp_coord(int'(r.offset_x));
          tbl_oy[s]  = clamp_coord(int'(r.offset_y));
          tbl_vld[s] = 1'b1;
        end
      end
      ACT_SETPOS: begin
        // ignored for a slot without collider
        if (in_tbl && tbl_vld[s]) begin
          tbl_x[s] = clamp_coord(int'(r.pos_x) + int'(tbl_ox[s]));
          tbl_y[s] = clamp_coord(int'(r.pos_y) + int'(tbl_oy[s]));
        end
      end
      ACT_MOVE: begin
        mx    = int'(r.move_x);
        my    = int'(r.move_y);
        hit_x = 1'b0;
        hit_y = 1'b0;
        has   = in_tbl && tbl_vld[s];
        if (has) begin
          ox = int'(tbl_x[s]);
          oy = int'(tbl_y[s]);
          ow = int'(tbl_w[s]);
          oh = int'(tbl_h[s]);
          // trial rectangles at full precision, the own slot is skipped
          for (k = 0; k < NSLOT; k++) begin
            if (k != s && tbl_vld[k]) begin
              if (boxes_overlap(ox + mx, oy, ow, oh, k)) hit_x = 1'b1;
              if (boxes_overlap(ox, oy + my, ow, oh, k)) hit_y = 1'b1;
            end
          end
        end
        // both axes blocked gives no result item
        if (!(hit_x && hit_y)) begin
          g.vel_x        = hit_x ? '0 : r.move_x;
          g.vel_y        = hit_y ? '0 : r.move_y;
          g.had_collider = has;
          grant_q.push_back(g);
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------
  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // every field random, so unused fields still toggle
  function automatic req_t blank_req();
    req_t r;
    r.action   = ACT_UNUSED;
    r.slot     = SLOT_W'($urandom);
    r.rect_x   = FIELD_W'($urandom);
    r.rect_y   = FIELD_W'($urandom);
    r.rect_w   = SIZE_W'($urandom);
    r.rect_h   = SIZE_W'($urandom);
    r.offset_x = FIELD_W'($urandom);
    r.offset_y = FIELD_W'($urandom);
    r.pos_x    = FIELD_W'($urandom);
    r.pos_y    = FIELD_W'($urandom);
    r.move_x   = FIELD_W'($urandom);
    r.move_y   = FIELD_W'($urandom);
    return r;
  endfunction

  function automatic void add_load(int slot, int x, int y, int w, int h, int ox, int oy);
    req_t r;
    r          = blank_req();
    r.action   = ACT_LOAD;
    r.slot     = SLOT_W'(slot);
    r.rect_x   = FIELD_W'(x);
    r.rect_y   = FIELD_W'(y);
    r.rect_w   = SIZE_W'(w);
    r.rect_h   = SIZE_W'(h);
    r.offset_x = FIELD_W'(ox);
    r.offset_y = FIELD_W'(oy);
    pend_q.push_back(r);
  endfunction

  function automatic void add_setpos(int slot, int px, int py);
    req_t r;
    r        = blank_req();
    r.action = ACT_SETPOS;
    r.slot   = SLOT_W'(slot);
    r.pos_x  = FIELD_W'(px);
    r.pos_y  = FIELD_W'(py);
    pend_q.push_back(r);
  endfunction

  function automatic void add_move(int slot, int mx, int my);
    req_t r;
    r        = blank_req();
    r.action = ACT_MOVE;
    r.slot   = SLOT_W'(slot);
    r.move_x = FIELD_W'(mx);
    r.move_y = FIELD_W'(my);
    pend_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    req_t r;
    int   n, pick, crowd, slot, w, h;

    // known levels from time zero
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_UNUSED;
    in_if.slot      = '0;
    in_if.rect_x    = '0;
    in_if.rect_y    = '0;
    in_if.rect_w    = '0;
    in_if.rect_h    = '0;
    in_if.offset_x  = '0;
    in_if.offset_y  = '0;
    in_if.pos_x     = '0;
    in_if.pos_y     = '0;
    in_if.move_x    = '0;
    in_if.move_y    = '0;
    out_if.ready    = 1'b0;
    for (n = 0; n < NSLOT; n++) tbl_vld[n] = 1'b0;

    // directed part
    // move and set position on a slot without collider
    add_move(5, CRD_MIN, CRD_MAX);
    add_setpos(5, 1, 1);
    // unused action with every bit set
    r          = blank_req();
    r.slot     = '1;
    r.rect_x   = '1;
    r.rect_y   = '1;
    r.rect_w   = '1;
    r.rect_h   = '1;
    r.offset_x = '1;
    r.offset_y = '1;
    r.pos_x    = '1;
    r.pos_y    = '1;
    r.move_x   = '1;
    r.move_y   = '1;
    pend_q.push_back(r);
    // lone collider at the field extremes: nothing to test against
    add_load(0, CRD_MIN, CRD_MIN, 32767, 32767, CRD_MAX, CRD_MAX);
    add_move(0, CRD_MAX, CRD_MIN);
    // position plus offset saturating high, then back inside the range
    add_setpos(0, CRD_MAX, CRD_MAX);
    add_move(0, 1, 1);
    add_setpos(0, CRD_MIN, CRD_MIN);
    // highest slot, saturating low
    add_load(63, 0, 0, 10, 10, CRD_MIN, CRD_MIN);
    add_setpos(63, CRD_MIN, CRD_MIN);
    add_move(63, 0, 0);
    // empty rectangle never overlaps
    add_load(0, 0, 0, 0, 32767, 0, 0);
    // small scene: slot 2 to the right of slot 1, slot 3 below it
    add_load(1, 0, 0, 10, 10, 0, 0);
    add_load(2, 20, 0, 10, 10, 0, 0);
    add_load(3, 0, 20, 10, 10, 0, 0);
    add_move(1, 10, 0);     // edges just touch, not blocked
    add_move(1, 11, 0);     // x blocked
    add_move(1, 11, 11);    // both blocked, no result
    add_move(1, 0, 11);     // y blocked
    add_move(1, -5, 11);
    add_load(4, 0, 0, 5, 0, 0, 0);
    add_move(4, 1, 1);      // own rectangle empty
    add_move(1, 1, 1);
    add_setpos(1, 15, 0);   // now already overlapping slot 2
    add_move(1, 0, 0);      // both blocked by standing overlap
    add_move(2, CRD_MIN, CRD_MAX);

    // random part: a crowd of small rectangles in a small arena so that
    // moves collide often, with some full-range noise
    crowd = 8;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) crowd = spread(2, 16);
      slot = ($urandom_range(0, 19) == 0) ? spread(0, NSLOT - 1) : spread(0, crowd - 1);
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        w = ($urandom_range(0, 7) == 0) ? 0 : spread(1, 48);
        h = ($urandom_range(0, 7) == 0) ? 0 : spread(1, 48);
        add_load(slot, spread(-120, 120), spread(-120, 120), w, h,
                 spread(-16, 16), spread(-16, 16));
      end else if (pick < 34) begin
        add_setpos(slot, spread(-120, 120), spread(-120, 120));
      end else if (pick < 86) begin
        if ($urandom_range(0, 6) == 0)
          add_move(slot, spread(CRD_MIN, CRD_MAX), spread(CRD_MIN, CRD_MAX));
        else
          add_move(slot, spread(-24, 24), spread(-24, 24));
      end else if (pick < 93) begin
        // full-range item of any action
        r        = blank_req();
        r.action = ACTION_W'($urandom_range(0, 3));
        pend_q.push_back(r);
      end else begin
        // far positions plus the stored offsets, saturation either way
        add_setpos(slot, spread(CRD_MIN, CRD_MAX), spread(CRD_MIN, CRD_MAX));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all items taken and all grants back, then let a last move finish
    while (pend_q.size() != 0 || grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (n_bad == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: holds an item until taken, idles in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        resolve_item(pend_q.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        // item waits, payload stays put
      end else if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_if.action   <= pend_q[0].action;
        in_if.slot     <= pend_q[0].slot;
        in_if.rect_x   <= pend_q[0].rect_x;
        in_if.rect_y   <= pend_q[0].rect_y;
        in_if.rect_w   <= pend_q[0].rect_w;
        in_if.rect_h   <= pend_q[0].rect_h;
        in_if.offset_x <= pend_q[0].offset_x;
        in_if.offset_y <= pend_q[0].offset_y;
        in_if.pos_x    <= pend_q[0].pos_x;
        in_if.pos_y    <= pend_q[0].pos_y;
        in_if.move_x   <= pend_q[0].move_x;
        in_if.move_y   <= pend_q[0].move_y;
        in_if.valid    <= 1'b1;
        // idle density changes now and then, zero means a clean stretch
        if (pend_q.size() % 64 == 0)
          src_odds = ($urandom_range(0, 2) == 0) ? 0 : spread(2, 8);
        if (pend_q.size() > QUIET_TAIL && src_odds != 0 && $urandom_range(1, src_odds) == 1)
          src_gap = spread(1, 7);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each result against the oldest grant, stalls at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("result (%0d,%0d,%0b) with no move pending",
                                    out_if.vel_x, out_if.vel_y, out_if.had_collider));
        end else begin
          due = grant_q.pop_front();
          if (out_if.vel_x !== due.vel_x || out_if.vel_y !== due.vel_y ||
              out_if.had_collider !== due.had_collider)
            report_mismatch($sformatf("move result (%0d,%0d,%0b), want (%0d,%0d,%0b)",
                                      out_if.vel_x, out_if.vel_y, out_if.had_collider,
                                      due.vel_x, due.vel_y, due.had_collider));
        end
      end
      snk_cyc++;
      if (snk_cyc % 256 == 0)
        snk_odds = ($urandom_range(0, 2) == 0) ? 0 : spread(2, 8);
      if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (pend_q.size() > QUIET_TAIL && snk_odds != 0 && $urandom_range(1, snk_odds) == 1)
          snk_gap = spread(1, 7);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no item moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule

// ===== files.f =====
src/ambr_pkg.sv
src/ambr_in_if.sv
src/ambr_out_if.sv
src/ambr_table.sv
src/ambr_overlap_unit.sv
src/aabb_axis_move_resolver.sv
tb/sv/tb.sv
